>>> hdl/rgqp_pkg.sv
// Package with the shared types and constants of the queens placer.
`default_nettype none
package rgqp_pkg;
    localparam int unsigned RandW = 32;
    localparam int unsigned RowW  = 5;
    localparam int unsigned SizeW = 6;
    localparam int unsigned Rows  = 32;

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_DEAD_END = 2'd1,
        ST_COMPLETE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DIV,
        FSM_PICK
    } t_fsm;

    // Control from the sequencer to the row cells.
    typedef struct packed {
        logic         clear;
        logic         load;
        logic         shift;
        logic         commit;
        logic [RowW-1:0] chosen;
    } t_cell_ctrl;
endpackage
`default_nettype wire

>>> hdl/rgqp_if.sv
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface rgqp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_value;
    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

interface rgqp_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] column;
    logic [4:0] row;
    logic [1:0] status;
    modport source (output valid, output column, output row, output status, input ready);
    modport sink   (input valid, input column, input row, input status, output ready);
endinterface
`default_nettype wire

>>> hdl/random_greedy_queens_placer.sv
// Top level of the randomized greedy N-queens placer.
//   channel   dir  handshake    payload
//   in_ch     in   valid/ready  random_value[31:0]
//   out_ch    out  valid/ready  column[4:0], row[4:0], status[1:0]
//   cfg       in   i_cfg_we     i_cfg_wdata[5:0] (board_size)
// From acceptance to a valid result an item goes through a safe-row load, shifts of the
// cell chain over the N rows in use counting safe rows, a 32-step restoring divider for
// the modulo, a reload and shifts of the chain until the picked rank reaches row 0.
// A dead end skips the pick.
// Reset is synchronous, active low, and clears the board; board_size resets to 8.
// Input is accepted whenever the sequencer is idle; a result waits in the output
// register, and the sequencer holds before emitting while that register is still full.
`default_nettype none
module random_greedy_queens_placer #(
    parameter int unsigned MAX_SIZE = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [5:0]   i_cfg_wdata,
    rgqp_in_if.sink     in_ch,
    rgqp_out_if.source  out_ch
);
    import rgqp_pkg::*;

    localparam int unsigned Limit = (MAX_SIZE < Rows) ? MAX_SIZE : Rows;
    localparam int unsigned DiagW = 2 * Rows - 1;

    logic [SizeW-1:0] r_board_size;
    logic [SizeW-1:0] r_col;
    logic [Rows-1:0]  w_taken;
    logic [DiagW-1:0] r_rise;
    logic [DiagW-1:0] r_fall;
    logic [RowW-1:0]  r_placed [MAX_SIZE];
    t_fsm             r_fsm, n_fsm;
    logic [RandW-1:0] r_rand, n_rand;
    logic [RandW-1:0] r_rem, n_rem;
    logic [5:0]       r_cnt, n_cnt;
    logic [5:0]       r_step, n_step;
    logic [5:0]       r_n, n_n;
    logic [5:0]       r_c, n_c;
    logic             r_ovalid;
    logic [4:0]       r_ocol, r_orow;
    t_status          r_ostat;
    logic             w_emit;
    logic [4:0]       w_ecol, w_erow;
    t_status          w_estat;
    t_cell_ctrl       w_ctrl;
    logic             w_clear_board;
    logic [Rows-1:0]  w_safe;
    logic [Rows-1:0]  w_flag;
    logic [5:0]       w_size;
    logic [RandW:0]   w_trial;
    logic             w_out_free;

    // Size in use, saturated into 1..Limit.
    always_comb begin
        if (r_board_size == '0) begin
            w_size = 6'd1;
        end else if (r_board_size > 6'(Limit)) begin
            w_size = 6'(Limit);
        end else begin
            w_size = r_board_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= 6'd8;
        end else if (i_cfg_we) begin
            r_board_size <= i_cfg_wdata;
        end
    end

    // Safe flags of every row for the column in r_c.
    always_comb begin
        for (int r = 0; r < Rows; r++) begin
            w_safe[r] = (6'(r) < r_n) && !w_taken[r]
                        && !r_rise[6'(r) + r_c]
                        && !r_fall[6'(r) + 6'd31 - r_c];
        end
    end

    // Row cell chain; flags shift toward row 0 where the sequencer reads them.
    for (genvar g = 0; g < Rows; g++) begin : g_cell
        logic w_prev;
        if (g == Rows - 1) begin : g_end
            assign w_prev = 1'b0;
        end else begin : g_mid
            assign w_prev = w_flag[g+1];
        end
        rgqp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_row_idx  (RowW'(g)),
            .i_safe_now (w_safe[g]),
            .i_prev_flag(w_prev),
            .o_taken    (w_taken[g]),
            .o_flag     (w_flag[g])
        );
    end

    assign w_trial = {r_rem, r_rand[RandW-1]} - {27'd0, r_cnt};
    assign w_out_free = !r_ovalid || out_ch.ready;
    assign in_ch.ready = (r_fsm == FSM_IDLE);

    // Sequencer: scan, divide, pick.
    always_comb begin
        n_fsm  = r_fsm;
        n_rand = r_rand;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_step = r_step;
        n_n    = r_n;
        n_c    = r_c;
        w_ctrl = '0;
        w_clear_board = 1'b0;
        w_emit  = 1'b0;
        w_ecol  = r_c[4:0];
        w_erow  = '0;
        w_estat = ST_PLACED;
        case (r_fsm)
            FSM_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    n_rand = in_ch.random_value;
                    n_n    = w_size;
                    if (r_col >= w_size) begin
                        w_clear_board = 1'b1;
                        w_ctrl.clear  = 1'b1;
                        n_c = '0;
                    end else begin
                        n_c = r_col;
                    end
                    n_fsm = FSM_SCAN;
                    n_step = 6'd0;
                    n_cnt = '0;
                end
            end
            FSM_SCAN: begin
                if (r_step == 6'd0) begin
                    w_ctrl.load = 1'b1;
                    n_step = 6'd1;
                end else begin
                    n_cnt = r_cnt + {5'd0, w_flag[0]};
                    w_ctrl.shift = 1'b1;
                    if (r_step == r_n) begin
                        n_step = '0;
                        n_rem  = '0;
                        n_fsm  = FSM_DIV;
                    end else begin
                        n_step = r_step + 6'd1;
                    end
                end
            end
            FSM_DIV: begin
                if (r_cnt == '0) begin
                    // Dead end waits here until the output register can take it.
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        w_estat = ST_DEAD_END;
                        w_clear_board = 1'b1;
                        w_ctrl.clear  = 1'b1;
                        n_fsm = FSM_IDLE;
                    end
                end else begin
                    if (!w_trial[RandW]) begin
                        n_rem = w_trial[RandW-1:0];
                    end else begin
                        n_rem = {r_rem[RandW-2:0], r_rand[RandW-1]};
                    end
                    n_rand = {r_rand[RandW-2:0], 1'b0};
                    if (r_step == 6'd31) begin
                        n_step = '0;
                        n_fsm  = FSM_PICK;
                    end else begin
                        n_step = r_step + 6'd1;
                    end
                end
            end
            FSM_PICK: begin
                if (r_step == 6'd0) begin
                    w_ctrl.load = 1'b1;
                    n_step = 6'd1;
                end else begin
                    w_ctrl.shift = 1'b1;
                    n_step = r_step + 6'd1;
                    if (w_flag[0]) begin
                        if (r_rem[5:0] == '0) begin
                            // The chain holds still until the output register is free.
                            w_ctrl.shift = 1'b0;
                            n_step = r_step;
                            if (w_out_free) begin
                                w_ctrl.commit = 1'b1;
                                w_ctrl.chosen = 5'(r_step - 6'd1);
                                w_erow = 5'(r_step - 6'd1);
                                w_emit = 1'b1;
                                if (r_c + 6'd1 >= r_n) begin
                                    w_estat = ST_COMPLETE;
                                    w_clear_board = 1'b1;
                                    w_ctrl.clear = 1'b1;
                                end
                                n_fsm = FSM_IDLE;
                            end
                        end else begin
                            n_rem = r_rem - 32'd1;
                        end
                    end
                end
            end
            default: n_fsm = FSM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= FSM_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
        r_rand <= n_rand;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_step <= n_step;
        r_n    <= n_n;
        r_c    <= n_c;
    end

    // Board state: column pointer and diagonal masks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_rise <= '0;
            r_fall <= '0;
        end else if (w_clear_board) begin
            r_col  <= '0;
            r_rise <= '0;
            r_fall <= '0;
        end else if (w_ctrl.commit) begin
            r_col <= r_c + 6'd1;
            r_rise[6'(w_ctrl.chosen) + r_c] <= 1'b1;
            r_fall[6'(w_ctrl.chosen) + 6'd31 - r_c] <= 1'b1;
        end
    end

    // Record of placements, write only.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.commit && 32'(r_c) < MAX_SIZE) begin
            r_placed[r_c[$clog2(MAX_SIZE)-1:0]] <= w_ctrl.chosen;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
        if (w_emit) begin
            r_ocol  <= w_ecol;
            r_orow  <= w_erow;
            r_ostat <= w_estat;
        end
    end

    assign out_ch.valid  = r_ovalid;
    assign out_ch.column = r_ocol;
    assign out_ch.row    = r_orow;
    assign out_ch.status = r_ostat;
endmodule
`default_nettype wire

>>> hdl/rgqp_cell.sv
// One row cell: holds row-taken state and passes its safe flag along the chain.
`default_nettype none
module rgqp_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire rgqp_pkg::t_cell_ctrl i_ctrl,
    input  wire [rgqp_pkg::RowW-1:0] i_row_idx,
    input  wire                     i_safe_now,
    input  wire                     i_prev_flag,
    output logic                    o_taken,
    output logic                    o_flag
);
    import rgqp_pkg::*;

    logic r_taken;
    logic r_flag;

    // Row occupancy, set when the queen lands in this row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_taken <= 1'b0;
        end else if (i_ctrl.commit && i_ctrl.chosen == i_row_idx) begin
            r_taken <= 1'b1;
        end
    end

    // Safe flag is loaded in parallel and then shifted toward row 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_ctrl.load) begin
            r_flag <= i_safe_now;
        end else if (i_ctrl.shift) begin
            r_flag <= i_prev_flag;
        end
    end

    assign o_taken = r_taken;
    assign o_flag  = r_flag;
endmodule
`default_nettype wire

>>> hdl/rgqp_checker.sv
// Port-level checker for the queens placer, bound to the top level.
`default_nettype none
module rgqp_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input wire [4:0] out_row,
    input wire [1:0] out_status
);
    import rgqp_pkg::*;

    a_status_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_status != 2'd3) else $error("bad status");
    a_dead_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status == ST_DEAD_END |-> out_row == '0) else $error("dead end row");
    a_hold_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_status)) else $error("status changed");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row)) else $error("result dropped");
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind random_greedy_queens_placer rgqp_checker u_rgqp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_row   (out_ch.row),
    .out_status(out_ch.status)
);
`default_nettype wire
